// ----- rtl/core/y2r_pkg.sv -----
// shared types, constants and helpers for the yuyv to rgb pixel writer
`default_nettype none

package y2r_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int IW_W    = 13;
    localparam int IH_W    = 13;
    localparam int FBW_W   = 14;
    localparam int BPP_W   = 3;
    localparam int CFG_W   = 14;
    localparam int IDX_W   = 2;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int FBLOC_W = 28;
    localparam int FBADR_W = 27;
    localparam int BMP_W   = 26;
    localparam int PIX_W   = 8;
    localparam int SUM_W   = 20;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FB_WIDTH     = 2'd2;
    localparam logic [IDX_W-1:0] REG_FB_BPP       = 2'd3;

    localparam logic [IW_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [IH_W-1:0]  RST_IMAGE_HEIGHT = 13'd360;
    localparam logic [FBW_W-1:0] RST_FB_WIDTH     = 14'd640;
    localparam logic [BPP_W-1:0] RST_FB_BPP       = 3'd4;
    localparam logic [BMP_W-1:0] RST_BMP_BASE     = BMP_W'((360 - 1) * 640 * 3);

    localparam logic signed [SUM_W-1:0] C_Y   = 20'sd298;
    localparam logic signed [SUM_W-1:0] C_VR  = 20'sd409;
    localparam logic signed [SUM_W-1:0] C_UG  = 20'sd100;
    localparam logic signed [SUM_W-1:0] C_VG  = 20'sd208;
    localparam logic signed [SUM_W-1:0] C_UB  = 20'sd516;
    localparam logic signed [SUM_W-1:0] C_RND = 20'sd128;

    typedef struct packed {
        logic               result;
        logic [FBADR_W-1:0] fb_addr;
        logic [BMP_W-1:0]   bmp_addr;
        logic               eof;
    } t_addr_info;

    // floor shift by 8 then clip to 0..255
    function automatic logic [PIX_W-1:0] clip8(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] q;
        begin
            if (s[SUM_W-1]) begin
                q = '0;
            end else if (|s[SUM_W-2:16]) begin
                q = '1;
            end else begin
                q = s[15:8];
            end
            return q;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/y2r_lane.sv -----
// one conversion lane: one luma with shared chroma to clipped bgr
`default_nettype none

module y2r_lane (
    input  wire logic [y2r_pkg::PIX_W-1:0] i_luma,
    input  wire logic [y2r_pkg::PIX_W-1:0] i_u,
    input  wire logic [y2r_pkg::PIX_W-1:0] i_v,
    output logic [y2r_pkg::PIX_W-1:0]      o_blue,
    output logic [y2r_pkg::PIX_W-1:0]      o_green,
    output logic [y2r_pkg::PIX_W-1:0]      o_red
);

    logic signed [y2r_pkg::SUM_W-1:0] w_y;
    logic signed [y2r_pkg::SUM_W-1:0] w_u;
    logic signed [y2r_pkg::SUM_W-1:0] w_v;
    logic signed [y2r_pkg::SUM_W-1:0] w_sum_b;
    logic signed [y2r_pkg::SUM_W-1:0] w_sum_g;
    logic signed [y2r_pkg::SUM_W-1:0] w_sum_r;

    // chroma minus 128 is the byte with its top bit flipped
    always_comb begin
        w_y = $signed({12'd0, i_luma}) * y2r_pkg::C_Y;
        w_u = y2r_pkg::SUM_W'($signed({~i_u[7], i_u[6:0]}));
        w_v = y2r_pkg::SUM_W'($signed({~i_v[7], i_v[6:0]}));
        w_sum_b = w_y + w_u * y2r_pkg::C_UB + y2r_pkg::C_RND;
        w_sum_g = w_y - w_u * y2r_pkg::C_UG - w_v * y2r_pkg::C_VG + y2r_pkg::C_RND;
        w_sum_r = w_y + w_v * y2r_pkg::C_VR + y2r_pkg::C_RND;
    end

    assign o_blue  = y2r_pkg::clip8(w_sum_b);
    assign o_green = y2r_pkg::clip8(w_sum_g);
    assign o_red   = y2r_pkg::clip8(w_sum_r);

endmodule

`default_nettype wire

// ----- rtl/core/y2r_addr.sv -----
// configuration registers, row and pair counters, framebuffer and bmp addressing
`default_nettype none

module y2r_addr (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [y2r_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [y2r_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                         i_accept,
    output y2r_pkg::t_addr_info               o_info
);

    logic [y2r_pkg::IW_W-1:0]    r_image_width, n_image_width;
    logic [y2r_pkg::IH_W-1:0]    r_image_height, n_image_height;
    logic [y2r_pkg::FBW_W-1:0]   r_fb_width, n_fb_width;
    logic [y2r_pkg::BPP_W-1:0]   r_bpp, n_bpp;
    logic [y2r_pkg::COL_W-1:0]   r_col, n_col;
    logic [y2r_pkg::ROW_W-1:0]   r_row, n_row;
    logic [y2r_pkg::FBLOC_W-1:0] r_fb_loc, n_fb_loc;
    logic [y2r_pkg::BMP_W-1:0]   r_bmp_base, n_bmp_base;

    logic [y2r_pkg::IW_W-1:0]    w_eff_w, w_next_eff_w;
    logic [y2r_pkg::IH_W-1:0]    w_eff_h, w_next_eff_h;
    logic [y2r_pkg::COL_W-1:0]   w_pairs;
    logic [y2r_pkg::FBW_W:0]     w_fb_sum;
    logic [y2r_pkg::FBW_W-1:0]   w_fb_pairs;
    logic [y2r_pkg::FBW_W-1:0]   w_last_col;
    logic [y2r_pkg::FBW_W-1:0]   w_pair_diff;
    logic [17:0]                 w_gap;
    logic [17:0]                 w_gap_bytes;
    logic [y2r_pkg::COL_W:0]     w_col_p1;
    logic [y2r_pkg::ROW_W:0]     w_row_p1;
    logic                        w_result;
    logic                        w_row_end;
    logic                        w_last_row;
    logic [14:0]                 w_w3, w_next_w3;
    logic [26:0]                 w_first_prod;
    logic [y2r_pkg::BMP_W-1:0]   w_first_base;

    function automatic logic [y2r_pkg::IW_W-1:0] eff_w(input logic [y2r_pkg::IW_W-1:0] iw);
        logic [y2r_pkg::IW_W-1:0] w;
        begin
            w = {iw[y2r_pkg::IW_W-1:1], 1'b0};
            if (w < y2r_pkg::IW_W'(2)) begin
                w = y2r_pkg::IW_W'(2);
            end else if (w > y2r_pkg::IW_W'(y2r_pkg::MAX_WIDTH)) begin
                w = y2r_pkg::IW_W'(y2r_pkg::MAX_WIDTH);
            end
            return w;
        end
    endfunction

    function automatic logic [y2r_pkg::IH_W-1:0] eff_h(input logic [y2r_pkg::IH_W-1:0] ih);
        logic [y2r_pkg::IH_W-1:0] h;
        begin
            h = ih;
            if (h < y2r_pkg::IH_W'(1)) begin
                h = y2r_pkg::IH_W'(1);
            end else if (h > y2r_pkg::IH_W'(y2r_pkg::MAX_HEIGHT)) begin
                h = y2r_pkg::IH_W'(y2r_pkg::MAX_HEIGHT);
            end
            return h;
        end
    endfunction

    // register writes
    always_comb begin
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        n_fb_width     = r_fb_width;
        n_bpp          = r_bpp;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                y2r_pkg::REG_IMAGE_WIDTH:  n_image_width  = i_cfg_data[y2r_pkg::IW_W-1:0];
                y2r_pkg::REG_IMAGE_HEIGHT: n_image_height = i_cfg_data[y2r_pkg::IH_W-1:0];
                y2r_pkg::REG_FB_WIDTH:     n_fb_width     = i_cfg_data;
                y2r_pkg::REG_FB_BPP:       n_bpp          = i_cfg_data[y2r_pkg::BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // derived geometry
    always_comb begin
        w_eff_w      = eff_w(r_image_width);
        w_eff_h      = eff_h(r_image_height);
        w_next_eff_w = eff_w(n_image_width);
        w_next_eff_h = eff_h(n_image_height);
        w_pairs      = w_eff_w[y2r_pkg::IW_W-1:1];
        w_fb_sum     = {1'b0, r_fb_width} + 15'd1;
        w_fb_pairs   = w_fb_sum[y2r_pkg::FBW_W:1];
        w_last_col   = (w_fb_pairs < {2'b0, w_pairs}) ? w_fb_pairs : {2'b0, w_pairs};
        w_pair_diff  = w_fb_pairs - {2'b0, w_pairs};
        w_gap        = {4'd0, w_pair_diff} * {15'd0, r_bpp};
        w_gap_bytes  = {w_gap[16:0], 1'b0};
        w_w3         = {2'b0, w_eff_w} + {1'b0, w_eff_w, 1'b0};
        w_next_w3    = {2'b0, w_next_eff_w} + {1'b0, w_next_eff_w, 1'b0};
        w_first_prod = {15'd0, w_next_eff_h[11:0] - 12'd1} * {12'd0, w_next_w3};
        w_first_base = w_first_prod[y2r_pkg::BMP_W-1:0];
    end

    // per request status
    always_comb begin
        w_col_p1   = {1'b0, r_col} + 13'd1;
        w_row_p1   = {1'b0, r_row} + 13'd1;
        w_result   = {2'b0, r_col} < w_fb_pairs;
        w_row_end  = w_col_p1 >= {1'b0, w_pairs};
        w_last_row = w_row_p1 >= w_eff_h;

        o_info.result   = w_result;
        o_info.fb_addr  = r_fb_loc[y2r_pkg::FBADR_W-1:0];
        o_info.bmp_addr = r_bmp_base + {12'd0, r_col, 2'b0} + {13'd0, r_col, 1'b0};
        o_info.eof      = w_last_row && ({1'b0, w_col_p1} == w_last_col);
    end

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_fb_loc   = r_fb_loc;
        n_bmp_base = r_bmp_base;
        if (i_accept) begin
            n_fb_loc = r_fb_loc + (w_result ? 28'd8 : 28'd0)
                + ((w_row_end && (w_fb_pairs > {2'b0, w_pairs})) ? {10'd0, w_gap_bytes} : 28'd0);
            if (w_row_end) begin
                n_col = '0;
                if (w_last_row) begin
                    n_row      = '0;
                    n_fb_loc   = '0;
                    n_bmp_base = w_first_base;
                end else begin
                    n_row      = w_row_p1[y2r_pkg::ROW_W-1:0];
                    n_bmp_base = r_bmp_base - {11'd0, w_w3};
                end
            end else begin
                n_col = w_col_p1[y2r_pkg::COL_W-1:0];
            end
        end else if (i_cfg_wr_en && (r_col == '0) && (r_row == '0)) begin
            n_bmp_base = w_first_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= y2r_pkg::RST_IMAGE_WIDTH;
            r_image_height <= y2r_pkg::RST_IMAGE_HEIGHT;
            r_fb_width     <= y2r_pkg::RST_FB_WIDTH;
            r_bpp          <= y2r_pkg::RST_FB_BPP;
            r_col          <= '0;
            r_row          <= '0;
            r_fb_loc       <= '0;
            r_bmp_base     <= y2r_pkg::RST_BMP_BASE;
        end else begin
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_fb_width     <= n_fb_width;
            r_bpp          <= n_bpp;
            r_col          <= n_col;
            r_row          <= n_row;
            r_fb_loc       <= n_fb_loc;
            r_bmp_base     <= n_bmp_base;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/yuyv_to_rgb_pixel_writer.sv -----
// top level: yuyv macropixel to bgr pixel pair with framebuffer and bmp addresses
//
//  channel   signals                           direction  handshake
//  in        first_luma blue_diff second_luma  input      i_in_valid / o_in_stall
//            red_diff
//  out       blue/green/red a and b, fb and    output     o_out_valid / i_out_stall
//            bmp byte address, end_of_frame
//  cfg       i_cfg_wr_en i_cfg_index           input      write enable only
//            i_cfg_data
//
//  one request per cycle while not stalled; a result leaves through the addressing
//  register, then the two color lanes into the output register
//  a request beyond the framebuffer width is taken and gives no result
//  synchronous active low reset clears counters and restores register defaults
//  stall on the output backs up through both stages to o_in_stall
`default_nettype none

module yuyv_to_rgb_pixel_writer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [y2r_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [y2r_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [y2r_pkg::PIX_W-1:0]     i_first_luma,
    input  wire logic [y2r_pkg::PIX_W-1:0]     i_blue_diff,
    input  wire logic [y2r_pkg::PIX_W-1:0]     i_second_luma,
    input  wire logic [y2r_pkg::PIX_W-1:0]     i_red_diff,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [y2r_pkg::PIX_W-1:0]          o_blue_a,
    output logic [y2r_pkg::PIX_W-1:0]          o_green_a,
    output logic [y2r_pkg::PIX_W-1:0]          o_red_a,
    output logic [y2r_pkg::PIX_W-1:0]          o_blue_b,
    output logic [y2r_pkg::PIX_W-1:0]          o_green_b,
    output logic [y2r_pkg::PIX_W-1:0]          o_red_b,
    output logic [y2r_pkg::FBADR_W-1:0]        o_fb_byte_address,
    output logic [y2r_pkg::BMP_W-1:0]          o_bmp_byte_address,
    output logic                               o_end_of_frame
);

    y2r_pkg::t_addr_info w_info;
    logic                w_accept;
    logic                w_en1;
    logic                w_en2;

    logic                       r_v1;
    logic [y2r_pkg::PIX_W-1:0]  r_luma_a;
    logic [y2r_pkg::PIX_W-1:0]  r_luma_b;
    logic [y2r_pkg::PIX_W-1:0]  r_u;
    logic [y2r_pkg::PIX_W-1:0]  r_v;
    y2r_pkg::t_addr_info        r_info;

    logic [y2r_pkg::PIX_W-1:0]  w_blue_a, w_green_a, w_red_a;
    logic [y2r_pkg::PIX_W-1:0]  w_blue_b, w_green_b, w_red_b;

    logic                       r_v2;
    logic [y2r_pkg::PIX_W-1:0]  r_blue_a, r_green_a, r_red_a;
    logic [y2r_pkg::PIX_W-1:0]  r_blue_b, r_green_b, r_red_b;
    logic [y2r_pkg::FBADR_W-1:0] r_fb_addr;
    logic [y2r_pkg::BMP_W-1:0]  r_bmp_addr;
    logic                       r_eof;

    assign w_en2      = !r_v2 || !i_out_stall;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = !w_en1;
    assign w_accept   = i_in_valid && w_en1;

    y2r_addr u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .o_info      (w_info)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= w_accept && w_info.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_luma_a <= i_first_luma;
            r_luma_b <= i_second_luma;
            r_u      <= i_blue_diff;
            r_v      <= i_red_diff;
            r_info   <= w_info;
        end
    end

    y2r_lane u_lane_a (
        .i_luma  (r_luma_a),
        .i_u     (r_u),
        .i_v     (r_v),
        .o_blue  (w_blue_a),
        .o_green (w_green_a),
        .o_red   (w_red_a)
    );

    y2r_lane u_lane_b (
        .i_luma  (r_luma_b),
        .i_u     (r_u),
        .i_v     (r_v),
        .o_blue  (w_blue_b),
        .o_green (w_green_b),
        .o_red   (w_red_b)
    );

    // merge both lanes with the addressing into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_blue_a   <= w_blue_a;
            r_green_a  <= w_green_a;
            r_red_a    <= w_red_a;
            r_blue_b   <= w_blue_b;
            r_green_b  <= w_green_b;
            r_red_b    <= w_red_b;
            r_fb_addr  <= r_info.fb_addr;
            r_bmp_addr <= r_info.bmp_addr;
            r_eof      <= r_info.eof;
        end
    end

    assign o_out_valid        = r_v2;
    assign o_blue_a           = r_blue_a;
    assign o_green_a          = r_green_a;
    assign o_red_a            = r_red_a;
    assign o_blue_b           = r_blue_b;
    assign o_green_b          = r_green_b;
    assign o_red_b            = r_red_b;
    assign o_fb_byte_address  = r_fb_addr;
    assign o_bmp_byte_address = r_bmp_addr;
    assign o_end_of_frame     = r_eof;

endmodule

`default_nettype wire
